>>> design/wdom_pkg.sv
// Shared types, constants and calendar tables for the weekday-of-month date finder.
package wdom_pkg;

    localparam int NumStages = 8;

    // request opcodes; the unused code behaves as OP_FIRST
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_NTH   = 2'd1,
        OP_LAST  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] month_index;
        logic [2:0] weekday_wanted;
        logic [2:0] occurrence;
        logic [4:0] hour_of_day;
    } t_item;

    typedef struct packed {
        logic [NumStages-1:0] load;
        logic [NumStages-1:0] vld;
    } t_pipe_ctl;

    // seconds -> days: (now >> 7) * RecipDay >> RecipDayShift equals now / 86400
    localparam logic [25:0] RecipDay      = 26'd50903317;
    localparam int          RecipDayShift = 35;
    // days / 1461 for values below 2**16
    localparam logic [16:0] RecipCycle    = 17'd91868;
    localparam int          RecipCycShift = 27;
    // x / 7 for values below 104857
    localparam logic [16:0] Recip7        = 17'd74899;
    localparam int          Recip7Shift   = 19;

    localparam logic [15:0] DaysToMar1968 = 16'd671;   // 1968-03-01 .. 1970-01-01
    localparam logic [15:0] Mar2100Days   = 16'd47541; // 2100-03-01 in days since 1970
    localparam logic [15:0] DaysPerCycle  = 16'd1461;
    localparam logic [7:0]  Yo2100        = 8'd132;    // 2100 - 1968
    localparam logic [32:0] SecsPerDay    = 33'd86400;
    localparam logic [32:0] SecsPerHour   = 33'd3600;

    // day of the March-based year on which a month starts; month 0 is January
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd0:    d = 9'd306;
            4'd1:    d = 9'd337;
            4'd2:    d = 9'd0;
            4'd3:    d = 9'd31;
            4'd4:    d = 9'd61;
            4'd5:    d = 9'd92;
            4'd6:    d = 9'd122;
            4'd7:    d = 9'd153;
            4'd8:    d = 9'd184;
            4'd9:    d = 9'd214;
            4'd10:   d = 9'd245;
            4'd11:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] n;
        case (mon)
            4'd1:                      n = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // (dim - 1) mod 7
    function automatic logic [2:0] last_day_mod7(input logic [4:0] dim);
        logic [2:0] r;
        case (dim)
            5'd28:   r = 3'd6;
            5'd29:   r = 3'd0;
            5'd30:   r = 3'd1;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

endpackage

>>> design/wdom_pipe_ctl.sv
// Valid/ready control for the datapath stages: valid bits and per-stage load enables.
module wdom_pipe_ctl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output wdom_pkg::t_pipe_ctl  o_ctl
);

    localparam int N = wdom_pkg::NumStages;

    logic [N:0]   ready;
    logic [N-1:0] prev_vld;
    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;

    // a stage may load when it is empty or the stage after it moves
    always_comb begin
        ready[N] = i_out_ready;
        for (int s = N - 1; s >= 0; s--) begin
            ready[s] = ~r_vld[s] | ready[s+1];
        end
    end

    assign prev_vld = {r_vld[N-2:0], i_in_valid};
    assign n_vld    = (prev_vld & ready[N-1:0]) | (r_vld & ~ready[N-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = ready[0];
    assign o_ctl.load = ready[N-1:0];
    assign o_ctl.vld  = r_vld;

endmodule

>>> design/weekday_of_month_date_finder.sv
// Usage: finds the first, nth or last given weekday of a month and returns its time.
// Request channel: i_req_valid / o_req_ready with opcode, now_seconds, month_index,
//   weekday_wanted, occurrence and hour_of_day. Only the UTC year of now_seconds is used;
//   month_index 12..15 selects January..April of the following year.
// Response channel: o_rsp_valid / i_rsp_ready with transition_seconds and not_in_month.
//   A weekday code of 7, or an nth occurrence of 0 or past the month, returns
//   not_in_month = 1 and a time of zero.
// Throughput: one request per cycle while the receiver keeps i_rsp_ready high, set by
//   the eight-stage pipeline (the reciprocal multipliers for days, the 1461-day cycle
//   and mod 7 each own a stage).
// Reset: synchronous, active low; clears all stage valid bits, nothing else is kept.
// Stall: when the receiver holds i_rsp_ready low the response holds in the last stage;
//   earlier stages keep filling empty slots, so requests are taken until every stage
//   holds one, then o_req_ready drops. Nothing is lost or repeated.
module weekday_of_month_date_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_now_seconds,
    input  logic [3:0]  i_month_index,
    input  logic [2:0]  i_weekday_wanted,
    input  logic [2:0]  i_occurrence,
    input  logic [4:0]  i_hour_of_day,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [32:0] o_transition_seconds,
    output logic        o_not_in_month
);

    wdom_pkg::t_pipe_ctl w_ctl;

    wdom_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req_valid),
        .i_out_ready (i_rsp_ready),
        .o_in_ready  (o_req_ready),
        .o_ctl       (w_ctl)
    );

    wdom_pkg::t_item r_item [0:6];
    wdom_pkg::t_item in_item;

    logic [50:0] r_s0_prod, n_s0_prod;
    logic [15:0] r_s1_d,    n_s1_d;
    logic [15:0] r_s2_d;
    logic [5:0]  r_s2_q,    n_s2_q;
    logic [7:0]  r_s3_yo,   n_s3_yo;
    logic [15:0] r_s4_first, n_s4_first;
    logic [4:0]  r_s4_dim,   n_s4_dim;
    logic [32:0] r_s5_prod,  n_s5_prod;
    logic [15:0] r_s5_x,     n_s5_x;
    logic [15:0] r_s5_first;
    logic [4:0]  r_s5_dim;
    logic [15:0] r_s6_day,   n_s6_day;
    logic        r_s6_miss,  n_s6_miss;
    logic [32:0] r_s7_t,     n_s7_t;
    logic        r_s7_miss;

    logic [15:0] w_wdf16;

    assign in_item = '{opcode:         i_opcode,
                       month_index:    i_month_index,
                       weekday_wanted: i_weekday_wanted,
                       occurrence:     i_occurrence,
                       hour_of_day:    i_hour_of_day};

    // stage 0: seconds to days by reciprocal
    assign n_s0_prod = 51'(i_now_seconds[31:7]) * 51'(wdom_pkg::RecipDay);

    // stage 1: days since 1968-03-01, one day added past 2100-02-28
    always_comb begin
        logic [15:0] days;
        days   = r_s0_prod[50:wdom_pkg::RecipDayShift];
        n_s1_d = days + wdom_pkg::DaysToMar1968 + 16'(days >= wdom_pkg::Mar2100Days);
    end

    // stage 2: four-year cycle index
    always_comb begin
        logic [32:0] prod;
        prod   = 33'(r_s1_d) * 33'(wdom_pkg::RecipCycle);
        n_s2_q = prod[32:wdom_pkg::RecipCycShift];
    end

    // stage 3: year offset from 1968
    always_comb begin
        logic [15:0] rem;
        logic [1:0]  yoe;
        logic [10:0] doy;
        rem = r_s2_d - 16'(r_s2_q) * wdom_pkg::DaysPerCycle;
        if (rem[10:0] >= 11'd1095) begin
            yoe = 2'd3;
        end else if (rem[10:0] >= 11'd730) begin
            yoe = 2'd2;
        end else if (rem[10:0] >= 11'd365) begin
            yoe = 2'd1;
        end else begin
            yoe = 2'd0;
        end
        doy     = rem[10:0] - 11'(yoe) * 11'd365;
        n_s3_yo = {r_s2_q, 2'b00} + 8'(yoe) + 8'(doy >= 11'd306);
    end

    // stage 4: first of the month in days since 1970, month length
    always_comb begin
        logic [7:0]  yo_w;
        logic [3:0]  mon_w;
        logic        leap;
        logic [7:0]  k;
        logic        corr;
        logic [16:0] first17;
        if (r_item[3].month_index >= 4'd12) begin
            yo_w  = r_s3_yo + 8'd1;
            mon_w = r_item[3].month_index - 4'd12;
        end else begin
            yo_w  = r_s3_yo;
            mon_w = r_item[3].month_index;
        end
        leap    = (yo_w[1:0] == 2'b00) && (yo_w != wdom_pkg::Yo2100);
        k       = yo_w - 8'(mon_w <= 4'd1);
        corr    = (k >= wdom_pkg::Yo2100);
        first17 = 17'(k) * 17'd365 + 17'(k[7:2]) + 17'(wdom_pkg::month_start(mon_w))
                  - 17'(corr) - 17'(wdom_pkg::DaysToMar1968);
        n_s4_first = first17[15:0];
        n_s4_dim   = wdom_pkg::month_days(mon_w, leap);
    end

    // stage 5: weekday of the 1st, reciprocal of 7
    assign n_s5_x    = r_s4_first + 16'd4;
    assign n_s5_prod = 33'(n_s5_x) * 33'(wdom_pkg::Recip7);

    // stage 6: pick the day within the month
    assign w_wdf16 = r_s5_x - 16'(r_s5_prod[32:wdom_pkg::Recip7Shift]) * 16'd7;

    always_comb begin
        logic [2:0] wdf;
        logic [2:0] wd;
        logic [3:0] lead4;
        logic [2:0] lead;
        logic [3:0] s4;
        logic [2:0] lw;
        logic [3:0] b4;
        logic [2:0] back;
        logic [5:0] off_nth;
        logic [5:0] offset;
        logic       miss;
        wdf     = w_wdf16[2:0];
        wd      = r_item[5].weekday_wanted;
        lead4   = 4'(wd) + 4'd7 - 4'(wdf);
        lead    = (lead4 >= 4'd7) ? 3'(lead4 - 4'd7) : lead4[2:0];
        s4      = 4'(wdf) + 4'(wdom_pkg::last_day_mod7(r_s5_dim));
        lw      = (s4 >= 4'd7) ? 3'(s4 - 4'd7) : s4[2:0];
        b4      = 4'(lw) + 4'd7 - 4'(wd);
        back    = (b4 >= 4'd7) ? 3'(b4 - 4'd7) : b4[2:0];
        off_nth = 6'(lead) + 6'(r_item[5].occurrence) * 6'd7 - 6'd7;
        miss    = 1'b0;
        case (wdom_pkg::t_opcode'(r_item[5].opcode))
            wdom_pkg::OP_LAST: begin
                offset = 6'(r_s5_dim) - 6'd1 - 6'(back);
            end
            wdom_pkg::OP_NTH: begin
                offset = off_nth;
                miss   = (r_item[5].occurrence == 3'd0) || (off_nth >= 6'(r_s5_dim));
            end
            default: begin
                offset = 6'(lead);
            end
        endcase
        if (wd > 3'd6) begin
            miss = 1'b1;
        end
        n_s6_miss = miss;
        n_s6_day  = r_s5_first + 16'(offset);
    end

    // stage 7: day and hour to seconds
    assign n_s7_t = r_s6_miss ? 33'd0
                  : 33'(r_s6_day) * wdom_pkg::SecsPerDay
                    + 33'(r_item[6].hour_of_day) * wdom_pkg::SecsPerHour;

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[0]) begin
            r_item[0] <= in_item;
            r_s0_prod <= n_s0_prod;
        end
        for (int s = 1; s < 7; s++) begin
            if (w_ctl.load[s]) begin
                r_item[s] <= r_item[s-1];
            end
        end
        if (w_ctl.load[1]) begin
            r_s1_d <= n_s1_d;
        end
        if (w_ctl.load[2]) begin
            r_s2_d <= r_s1_d;
            r_s2_q <= n_s2_q;
        end
        if (w_ctl.load[3]) begin
            r_s3_yo <= n_s3_yo;
        end
        if (w_ctl.load[4]) begin
            r_s4_first <= n_s4_first;
            r_s4_dim   <= n_s4_dim;
        end
        if (w_ctl.load[5]) begin
            r_s5_prod  <= n_s5_prod;
            r_s5_x     <= n_s5_x;
            r_s5_first <= r_s4_first;
            r_s5_dim   <= r_s4_dim;
        end
        if (w_ctl.load[6]) begin
            r_s6_day  <= n_s6_day;
            r_s6_miss <= n_s6_miss;
        end
        if (w_ctl.load[7]) begin
            r_s7_t    <= n_s7_t;
            r_s7_miss <= r_s6_miss;
        end
    end

    assign o_rsp_valid          = w_ctl.vld[wdom_pkg::NumStages-1];
    assign o_transition_seconds = r_s7_t;
    assign o_not_in_month       = r_s7_miss;

    ap_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_not_in_month |-> o_transition_seconds == 33'd0)
        else $error("missing date carries a nonzero time");

    ap_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> w_ctl.vld[0])
        else $error("accepted request did not enter the first stage");

    ap_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.vld[3] |-> r_s3_yo >= 8'd2 && r_s3_yo <= 8'd138)
        else $error("year out of the 32-bit seconds range");

    ap_weekday_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.vld[5] |-> w_wdf16 <= 16'd6)
        else $error("mod 7 reciprocal gave a remainder above six");

endmodule
